/* rtl/sldf_pkg.sv */
// shared types and constants for the frame deframer
`timescale 1ns / 1ps

package sldf_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hF1;
  localparam logic [7:0] SYNC_SECOND = 8'hF2;
  localparam logic [7:0] END_MARK    = 8'hF9;
  localparam logic [7:0] LEN_LIMIT   = 8'hF0;
  localparam logic [7:0] LEN_MIN     = 8'h08;
  localparam logic [7:0] PAYLOAD_MAX = LEN_LIMIT - LEN_MIN - 8'd1;

  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_VERDICT = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [1:0] STATUS_BAD_END  = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] source_id;
    logic [7:0] dest_id;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [1:0] status;
    logic       for_us;
  } sldf_result_t;

endpackage

/* rtl/sldf_parser.sv */
// frame parser: phase tracking, header capture, running checksum and verdict
`timescale 1ns / 1ps

module sldf_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic [7:0]            rx_byte,
  input  logic                  cfg_wr_en,
  input  logic [7:0]            cfg_wr_data,
  output logic                  result_valid,
  output sldf_pkg::sldf_result_t result
);
  import sldf_pkg::*;

  localparam logic [3:0] PH_HUNT1   = 4'd0;
  localparam logic [3:0] PH_HUNT2   = 4'd1;
  localparam logic [3:0] PH_LEN     = 4'd2;
  localparam logic [3:0] PH_SRC     = 4'd3;
  localparam logic [3:0] PH_DST     = 4'd4;
  localparam logic [3:0] PH_CMD     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CSUM    = 4'd7;
  localparam logic [3:0] PH_END     = 4'd8;

  logic [3:0] phase, phase_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] held_source, held_source_next;
  logic [7:0] held_dest, held_dest_next;
  logic [7:0] held_command, held_command_next;
  logic       sum_matched, sum_matched_next;
  logic [7:0] own_address;
  logic [7:0] sum_add;

  assign sum_add = running_sum + rx_byte;

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    bytes_left_next   = bytes_left;
    running_sum_next  = running_sum;
    held_source_next  = held_source;
    held_dest_next    = held_dest;
    held_command_next = held_command;
    sum_matched_next  = sum_matched;
    result_valid      = 1'b0;
    result.kind           = KIND_PAYLOAD;
    result.payload_byte   = rx_byte;
    result.source_id      = held_source;
    result.dest_id        = held_dest;
    result.command        = held_command;
    result.payload_length = frame_length - LEN_MIN;
    result.status         = STATUS_OK;
    result.for_us         = (held_dest == own_address);
    case (phase)
      PH_HUNT1: begin
        if (rx_byte == SYNC_FIRST) phase_next = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (rx_byte == SYNC_SECOND) phase_next = PH_LEN;
        else if (rx_byte != SYNC_FIRST) phase_next = PH_HUNT1;
      end
      PH_LEN: begin
        if (rx_byte >= LEN_LIMIT || rx_byte < LEN_MIN) begin
          phase_next = (rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
        end else begin
          frame_length_next = rx_byte;
          bytes_left_next   = rx_byte - LEN_MIN;
          running_sum_next  = rx_byte;
          phase_next        = PH_SRC;
        end
      end
      PH_SRC: begin
        held_source_next = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_DST;
      end
      PH_DST: begin
        held_dest_next   = rx_byte;
        running_sum_next = sum_add;
        phase_next       = PH_CMD;
      end
      PH_CMD: begin
        held_command_next = rx_byte;
        running_sum_next  = sum_add;
        phase_next        = (bytes_left != 8'd0) ? PH_PAYLOAD : PH_CSUM;
      end
      PH_PAYLOAD: begin
        running_sum_next = sum_add;
        bytes_left_next  = bytes_left - 8'd1;
        if (bytes_left == 8'd1) phase_next = PH_CSUM;
        result_valid = 1'b1;
      end
      PH_CSUM: begin
        sum_matched_next = (rx_byte == running_sum);
        phase_next       = PH_END;
      end
      PH_END: begin
        phase_next          = PH_HUNT1;
        result_valid        = 1'b1;
        result.kind         = KIND_VERDICT;
        result.payload_byte = 8'd0;
        if (rx_byte != END_MARK) result.status = STATUS_BAD_END;
        else if (!sum_matched) result.status = STATUS_BAD_SUM;
        else result.status = STATUS_OK;
      end
      default: begin
        phase_next = PH_HUNT1;
      end
    endcase
    if (!accept) result_valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT1;
      frame_length <= 8'd0;
      bytes_left   <= 8'd0;
      running_sum  <= 8'd0;
      held_source  <= 8'd0;
      held_dest    <= 8'd0;
      held_command <= 8'd0;
      sum_matched  <= 1'b0;
      own_address  <= 8'd0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        bytes_left   <= bytes_left_next;
        running_sum  <= running_sum_next;
        held_source  <= held_source_next;
        held_dest    <= held_dest_next;
        held_command <= held_command_next;
        sum_matched  <= sum_matched_next;
      end
      if (cfg_wr_en) own_address <= cfg_wr_data;
    end
  end

endmodule

/* rtl/sldf_out_reg.sv */
// result register with valid/stall handshake toward the consumer
`timescale 1ns / 1ps

module sldf_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sldf_pkg::sldf_result_t load_data,
  input  logic                  res_stall,
  output logic                  full,
  output logic                  res_valid,
  output sldf_pkg::sldf_result_t res_data
);
  import sldf_pkg::*;

  logic         valid;
  sldf_result_t data;

  assign full      = valid && res_stall;
  assign res_valid = valid;
  assign res_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (!full) begin
      valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (!full && load) begin
      data <= load_data;
    end
  end

endmodule

/* rtl/sync_length_sum_frame_deframer_top.sv */
// a result is registered and appears in the cycle after the byte that causes it is accepted
// throughput: one byte per cycle; bytes are held off only while a result waits
// and the consumer stalls it
// reset: synchronous active-high rst returns to hunting for the first sync byte,
// clears the frame state and own_address, and empties the result register
`timescale 1ns / 1ps

module sync_length_sum_frame_deframer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  output logic       rx_stall,
  input  logic [7:0] rx_byte,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output logic       res_valid,
  input  logic       res_stall,
  output logic       kind,
  output logic [7:0] payload_byte,
  output logic [7:0] source_id,
  output logic [7:0] dest_id,
  output logic [7:0] command,
  output logic [7:0] payload_length,
  output logic [1:0] status,
  output logic       for_us
);
  import sldf_pkg::*;

  logic         accept;
  logic         result_valid;
  sldf_result_t result;
  sldf_result_t res_data;
  logic         full;

  assign rx_stall = full;
  assign accept   = rx_valid && !full;

  sldf_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .rx_byte      (rx_byte),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result       (result)
  );

  sldf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (result_valid),
    .load_data (result),
    .res_stall (res_stall),
    .full      (full),
    .res_valid (res_valid),
    .res_data  (res_data)
  );

  assign kind           = res_data.kind;
  assign payload_byte   = res_data.payload_byte;
  assign source_id      = res_data.source_id;
  assign dest_id        = res_data.dest_id;
  assign command        = res_data.command;
  assign payload_length = res_data.payload_length;
  assign status         = res_data.status;
  assign for_us         = res_data.for_us;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    rx_stall |-> res_valid && res_stall)
    else $error("input stalled without a waiting result");

  a_payload_status_ok: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_PAYLOAD |-> status == STATUS_OK)
    else $error("payload result carries a verdict status");

  a_length_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> payload_length <= PAYLOAD_MAX)
    else $error("payload length out of range");

  a_result_from_accept: assert property (@(posedge clk) disable iff (rst)
    res_valid && !$past(res_valid && res_stall) |-> $past(rx_valid && !rx_stall))
    else $error("result appeared without an accepted byte");

endmodule

/* test/tb_sync_length_sum_frame_deframer_top.sv */
// testbench for the frame deframer: directed and random byte streams checked against a predictor
`timescale 1ns / 1ps

module tb_sync_length_sum_frame_deframer_top;
  import sldf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 400;

  typedef enum logic [3:0] {
    HUNT_F1, HUNT_F2, GET_LEN, GET_SRC, GET_DST, GET_CMD, GET_PAYLOAD, GET_CSUM, GET_END
  } deframe_phase_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       rx_valid = 1'b0;
  logic       rx_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'h00;
  logic       res_valid;
  logic       res_stall = 1'b0;
  logic       kind;
  logic [7:0] payload_byte;
  logic [7:0] source_id;
  logic [7:0] dest_id;
  logic [7:0] command;
  logic [7:0] payload_length;
  logic [1:0] status;
  logic       for_us;

  // predictor state
  deframe_phase_t phase_q = HUNT_F1;
  logic [7:0] own_addr = 8'h00;
  logic [7:0] len_q = 8'h00;
  logic [7:0] left_q = 8'h00;
  logic [7:0] sum_q = 8'h00;
  logic [7:0] src_q = 8'h00;
  logic [7:0] dst_q = 8'h00;
  logic [7:0] cmd_q = 8'h00;
  logic       sum_ok_q = 1'b0;

  sldf_result_t frame_results_due[$];
  sldf_result_t want;
  sldf_result_t got;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int idle_cycles = 0;
  int errors = 0;
  int bytes_sent = 0;
  int payload_seen = 0;
  int ok_verdicts = 0;
  int bad_sum_verdicts = 0;
  int bad_end_verdicts = 0;

  sync_length_sum_frame_deframer_top u_top (
    .clk            (clk),
    .rst            (rst),
    .rx_valid       (rx_valid),
    .rx_stall       (rx_stall),
    .rx_byte        (rx_byte),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .kind           (kind),
    .payload_byte   (payload_byte),
    .source_id      (source_id),
    .dest_id        (dest_id),
    .command        (command),
    .payload_length (payload_length),
    .status         (status),
    .for_us         (for_us)
  );

  always #5 clk = ~clk;

  function automatic sldf_result_t frame_result(logic k, logic [7:0] pb, logic [1:0] st);
    sldf_result_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.source_id      = src_q;
    r.dest_id        = dst_q;
    r.command        = cmd_q;
    r.payload_length = len_q - LEN_MIN;
    r.status         = st;
    r.for_us         = (dst_q == own_addr);
    return r;
  endfunction

  task automatic predict_deframe(input logic [7:0] b);
    logic [1:0] st;
    case (phase_q)
      HUNT_F1: begin
        if (b == SYNC_FIRST) phase_q = HUNT_F2;
      end
      HUNT_F2: begin
        if (b == SYNC_SECOND) phase_q = GET_LEN;
        else if (b != SYNC_FIRST) phase_q = HUNT_F1;
      end
      GET_LEN: begin
        if (b >= LEN_LIMIT || b < LEN_MIN) begin
          phase_q = (b == SYNC_FIRST) ? HUNT_F2 : HUNT_F1;
        end else begin
          len_q   = b;
          left_q  = b - LEN_MIN;
          sum_q   = b;
          phase_q = GET_SRC;
        end
      end
      GET_SRC: begin
        src_q   = b;
        sum_q   = sum_q + b;
        phase_q = GET_DST;
      end
      GET_DST: begin
        dst_q   = b;
        sum_q   = sum_q + b;
        phase_q = GET_CMD;
      end
      GET_CMD: begin
        cmd_q   = b;
        sum_q   = sum_q + b;
        phase_q = (left_q != 8'd0) ? GET_PAYLOAD : GET_CSUM;
      end
      GET_PAYLOAD: begin
        sum_q  = sum_q + b;
        left_q = left_q - 8'd1;
        if (left_q == 8'd0) phase_q = GET_CSUM;
        frame_results_due.push_back(frame_result(KIND_PAYLOAD, b, STATUS_OK));
      end
      GET_CSUM: begin
        sum_ok_q = (b == sum_q);
        phase_q  = GET_END;
      end
      GET_END: begin
        if (b != END_MARK) st = STATUS_BAD_END;
        else if (!sum_ok_q) st = STATUS_BAD_SUM;
        else st = STATUS_OK;
        phase_q = HUNT_F1;
        frame_results_due.push_back(frame_result(KIND_VERDICT, 8'h00, st));
      end
      default: phase_q = HUNT_F1;
    endcase
  endtask

  // receiver side stall, with an optional long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      got = {kind, payload_byte, source_id, dest_id, command, payload_length, status, for_us};
      if (frame_results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        errors++;
      end else begin
        want = frame_results_due.pop_front();
        check_field("kind", 8'(want.kind), 8'(got.kind));
        check_field("payload_byte", want.payload_byte, got.payload_byte);
        check_field("source_id", want.source_id, got.source_id);
        check_field("dest_id", want.dest_id, got.dest_id);
        check_field("command", want.command, got.command);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("status", 8'(want.status), 8'(got.status));
        check_field("for_us", 8'(want.for_us), 8'(got.for_us));
        if (want.kind == KIND_PAYLOAD) payload_seen++;
        else if (want.status == STATUS_OK) ok_verdicts++;
        else if (want.status == STATUS_BAD_SUM) bad_sum_verdicts++;
        else bad_end_verdicts++;
      end
    end
  end

  always @(posedge clk) begin
    if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(posedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    predict_deframe(b);
    bytes_sent++;
  endtask

  task automatic wait_drained;
    rx_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
  endtask

  // pad until the predictor is back to hunting
  task automatic finish_frame;
    while (phase_q != HUNT_F1) send_byte(8'h00);
  endtask

  task automatic send_frame(input int plen, input logic [7:0] dst, input bit bad_sum,
                            input bit bad_end, input int keep);
    logic [7:0] q[$];
    logic [7:0] sum;
    logic [7:0] b;
    q = {SYNC_FIRST, SYNC_SECOND};
    b = 8'(plen) + LEN_MIN;
    q.push_back(b);
    sum = b;
    b = 8'($urandom_range(255));
    q.push_back(b);
    sum = sum + b;
    q.push_back(dst);
    sum = sum + dst;
    b = 8'($urandom_range(255));
    q.push_back(b);
    sum = sum + b;
    for (int i = 0; i < plen; i++) begin
      b = 8'($urandom_range(255));
      q.push_back(b);
      sum = sum + b;
    end
    if (bad_sum) sum = sum + 8'($urandom_range(1, 255));
    q.push_back(sum);
    b = 8'($urandom_range(255));
    if (b == END_MARK) b = 8'h00;
    q.push_back(bad_end ? b : END_MARK);
    if (keep > 0 && keep < q.size()) q = q[0:keep-1];
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic write_own_address(input logic [7:0] v);
    finish_frame();
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    own_addr = v;
  endtask

  // repeated first sync, length byte equal to the first sync, then a good empty frame
  task automatic test_sync_recovery;
    logic [7:0] seq[$];
    send_idle_pct = 0;
    recv_idle_pct = 0;
    seq = {8'hF1, 8'hF1, 8'hF2, 8'hF1, 8'hF2, 8'h08, 8'h00, 8'hFF, 8'h55, 8'h5C, 8'hF9};
    foreach (seq[i]) send_byte(seq[i]);
    wait_drained();
  endtask

  // checksum error addressed to us, then a bad end marker over a good checksum
  task automatic test_verdict_status;
    logic [7:0] seq[$];
    seq = {8'hF1, 8'hF2, 8'h09, 8'hFF, 8'h00, 8'h03, 8'h80, 8'h8C, 8'hF9,
           8'hF1, 8'hF2, 8'h08, 8'h12, 8'h34, 8'h56, 8'hA4, 8'h00};
    foreach (seq[i]) send_byte(seq[i]);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_bytes, input int s_pct, input int r_pct);
    int start;
    int pick;
    int plen;
    logic [7:0] dst;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(7))
            0: send_byte(SYNC_FIRST);
            1: send_byte(SYNC_SECOND);
            2: send_byte(END_MARK);
            3: send_byte(LEN_LIMIT);
            4: send_byte(LEN_MIN);
            default: send_byte(8'($urandom_range(255)));
          endcase
        end
      end else if (pick < 12) begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        case ($urandom_range(4))
          0: send_byte(8'h00);
          1: send_byte(LEN_MIN - 8'd1);
          2: send_byte(LEN_LIMIT);
          3: send_byte(8'hFF);
          default: send_byte(SYNC_FIRST);
        endcase
      end else begin
        pick = $urandom_range(99);
        if (pick < 85) plen = $urandom_range(0, 12);
        else if (pick < 97) plen = $urandom_range(13, 60);
        else plen = $urandom_range(61, PAYLOAD_MAX);
        dst = $urandom_range(1) ? own_addr : 8'($urandom_range(255));
        send_frame(plen, dst, $urandom_range(9) == 0, $urandom_range(9) == 0,
                   ($urandom_range(15) == 0) ? $urandom_range(1, plen + 7) : 0);
      end
    end
    finish_frame();
    wait_drained();
  endtask

  // results held off while a longest frame keeps arriving
  task automatic test_backpressure;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_left <= HOLD_CYCLES;
    send_frame(PAYLOAD_MAX, own_addr, 1'b0, 1'b0, 0);
    send_frame(20, 8'($urandom_range(255)), 1'b0, 1'b0, 0);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_sync_recovery();
    test_verdict_status();
    write_own_address(8'hFF);
    test_random_traffic(500, 23, 80);
    write_own_address(8'h00);
    test_backpressure();
    write_own_address(8'($urandom_range(255)));
    test_random_traffic(500, 80, 23);
    write_own_address(8'h5A);
    test_random_traffic(400, 0, 0);
    wait_drained();
    repeat (5) @(posedge clk);
    if (frame_results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, frame_results_due.size());
      errors++;
    end
    $display("run covered %0d bytes, %0d payload results, verdicts ok %0d bad sum %0d bad end %0d",
             bytes_sent, payload_seen, ok_verdicts, bad_sum_verdicts, bad_end_verdicts);
    $display("four node addresses, three idle mixes and one long result hold-off; %0d errors",
             errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sync_length_sum_frame_deframer_top.f */
rtl/sldf_pkg.sv
rtl/sldf_parser.sv
rtl/sldf_out_reg.sv
rtl/sync_length_sum_frame_deframer_top.sv
test/tb_sync_length_sum_frame_deframer_top.sv
